// ----- design/ras_pkg.sv -----
// shared types, codes and defaults for the rectangle alignment snap unit
package ras_pkg;

  localparam int COORD_BITS_DEF  = 24;
  localparam int MAX_TARGETS_DEF = 64;
  localparam int THR_W           = 23;
  localparam logic [THR_W-1:0] THR_RESET = 23'd128;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_SNAP_THRESHOLD = 1'b0;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic we;
    logic re;
    logic start;
    logic upd;
    logic fit;
    logic sel;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } stat_t;

endpackage

// ----- design/ras_if.sv -----
// stream interfaces for input items and snap results
interface ras_in_if #(parameter int C = 24);
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic signed [C-1:0] rect_left;
  logic signed [C-1:0] rect_top;
  logic signed [C-1:0] rect_right;
  logic signed [C-1:0] rect_bottom;
  logic signed [C-1:0] move_dx;
  logic signed [C-1:0] move_dy;
  modport source (output valid, operation, rect_left, rect_top, rect_right, rect_bottom,
                  move_dx, move_dy, input ready);
  modport sink (input valid, operation, rect_left, rect_top, rect_right, rect_bottom,
                move_dx, move_dy, output ready);
endinterface

interface ras_out_if #(parameter int C = 24);
  logic                valid;
  logic                ready;
  logic signed [C-1:0] snap_dx;
  logic signed [C-1:0] snap_dy;
  logic                row_active;
  logic signed [C-1:0] row_line_y;
  logic signed [C-1:0] row_line_start;
  logic signed [C-1:0] row_line_end;
  logic                column_active;
  logic signed [C-1:0] column_line_x;
  logic signed [C-1:0] column_line_start;
  logic signed [C-1:0] column_line_end;
  modport source (output valid, snap_dx, snap_dy, row_active, row_line_y, row_line_start,
                  row_line_end, column_active, column_line_x, column_line_start,
                  column_line_end, input ready);
  modport sink (input valid, snap_dx, snap_dy, row_active, row_line_y, row_line_start,
                row_line_end, column_active, column_line_x, column_line_start,
                column_line_end, output ready);
endinterface

// ----- design/rect_alignment_snap_unit.sv -----
// top level of the rectangle alignment snap unit
//
//  channel  | dir | handshake       | content
//  in_ch    | in  | valid/ready     | operation, rectangle, move
//  out_ch   | out | valid/ready     | adjusted move, row and column guides
//  apb      | in  | psel/penable    | snap_threshold at address 0
//
// clear and append are handled in the idle state; a query scans the stored targets,
// reading the target memory one entry per cycle, then runs the wait, fit, select and output states.
// reset is synchronous and clears the fill count, the sequencer and the output
// valid; the target memory is not cleared. a finished result waits in the output
// register, and a following query holds before its load until that transfer.
module rect_alignment_snap_unit #(
  parameter int COORD_BITS  = ras_pkg::COORD_BITS_DEF,
  parameter int MAX_TARGETS = ras_pkg::MAX_TARGETS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  ras_in_if.sink                      in_ch,
  ras_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ras_pkg::PADDR_W-1:0] paddr,
  input  logic [ras_pkg::PDATA_W-1:0] pwdata,
  output logic [ras_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import ras_pkg::*;

  localparam int AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CW = $clog2(MAX_TARGETS + 1);

  logic [THR_W-1:0] thr;
  cmd_t             cmd;
  stat_t            stat;
  logic [AW-1:0]    waddr, raddr;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SNAP_THRESHOLD) ? PDATA_W'(thr) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SNAP_THRESHOLD) begin
      thr <= pwdata[THR_W-1:0];
    end
  end

  ras_ctrl #(.MAX_TARGETS(MAX_TARGETS), .AW(AW), .CW(CW)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .operation(in_ch.operation),
    .in_ready(in_ch.ready), .cmd(cmd), .stat(stat), .waddr(waddr), .raddr(raddr)
  );

  ras_dp #(.C(COORD_BITS), .MAX_TARGETS(MAX_TARGETS), .AW(AW)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .waddr(waddr), .raddr(raddr),
    .thr(thr), .rect_left(in_ch.rect_left), .rect_top(in_ch.rect_top),
    .rect_right(in_ch.rect_right), .rect_bottom(in_ch.rect_bottom),
    .move_dx(in_ch.move_dx), .move_dy(in_ch.move_dy), .out_ch(out_ch)
  );

endmodule

// ----- design/ras_axis.sv -----
// per-axis edge match, neighbour search and equal-spacing fit
module ras_axis #(
  parameter int C = 24
) (
  input  logic                          clk,
  input  logic                          init,
  input  logic                          upd,
  input  logic                          fit,
  input  logic                          sel,
  input  logic [ras_pkg::THR_W-1:0]     thr,
  input  logic signed [C-1:0]           c_s0,
  input  logic signed [C-1:0]           c_s1,
  input  logic signed [C-1:0]           c_x0,
  input  logic signed [C-1:0]           c_x1,
  input  logic signed [C-1:0]           t_s0,
  input  logic signed [C-1:0]           t_s1,
  input  logic signed [C-1:0]           t_x0,
  input  logic signed [C-1:0]           t_x1,
  output logic                          active,
  output logic signed [C+3:0]           off,
  output logic signed [C-1:0]           line,
  output logic signed [C-1:0]           sp0,
  output logic signed [C-1:0]           sp1
);
  import ras_pkg::*;

  localparam int EW = C + 4;
  localparam int DW = (C + 2 > THR_W + 1) ? C + 2 : THR_W + 1;
  localparam int KW = (EW > THR_W + 1) ? EW : THR_W + 1;
  localparam logic signed [EW-1:0] HI = EW'((64'sd1 <<< (C - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] LO = -HI - EW'(1);

  function automatic logic signed [C-1:0] sat_c(input logic signed [EW-1:0] v);
    if (v > HI) return HI[C-1:0];
    else if (v < LO) return LO[C-1:0];
    else return v[C-1:0];
  endfunction

  // one tracker per candidate edge: low, high, center
  logic [DW-1:0]       best  [3];
  logic                found [3];
  logic signed [C:0]   eoff  [3];
  logic signed [C-1:0] eline [3];
  logic signed [C-1:0] esp0  [3];
  logic signed [C-1:0] esp1  [3];

  logic [DW-1:0]       best_next  [3];
  logic                found_next [3];
  logic signed [C:0]   eoff_next  [3];
  logic signed [C-1:0] eline_next [3];
  logic signed [C-1:0] esp0_next  [3];
  logic signed [C-1:0] esp1_next  [3];

  // nearest neighbours below and above
  logic                nlo_v, nhi_v;
  logic signed [C:0]   glo, ghi;
  logic signed [C-1:0] a_s1, a_x0, a_x1, b_s0, b_x0, b_x1;

  // registered fit stage
  logic                e_found, f_ok;
  logic signed [C:0]   e_off;
  logic signed [C-1:0] e_line, e_sp0, e_sp1, f_sp0, f_sp1;
  logic signed [EW-1:0] f_off, f_line;

  logic signed [C:0]   csum, tsum, g_lo, g_hi;
  logic signed [C-1:0] cs [3];
  logic signed [C-1:0] ts [3];
  logic signed [C-1:0] tsp0, tsp1;
  logic                ovl, is_lo, is_hi;

  assign csum  = (C+1)'(c_s0) + (C+1)'(c_s1);
  assign tsum  = (C+1)'(t_s0) + (C+1)'(t_s1);
  assign cs[0] = c_s0;
  assign cs[1] = c_s1;
  assign cs[2] = csum[C:1];
  assign ts[0] = t_s0;
  assign ts[1] = t_s1;
  assign ts[2] = tsum[C:1];
  assign tsp0  = (c_x0 < t_x0) ? c_x0 : t_x0;
  assign tsp1  = (c_x1 > t_x1) ? c_x1 : t_x1;
  assign ovl   = (t_x0 < c_x1) && (t_x1 > c_x0);
  assign is_lo = ovl && (t_s1 <= c_s0);
  assign is_hi = ovl && !(t_s1 <= c_s0) && (t_s0 >= c_s1);
  assign g_lo  = (C+1)'(c_s0) - (C+1)'(t_s1);
  assign g_hi  = (C+1)'(t_s0) - (C+1)'(c_s1);

  always_comb begin
    logic signed [C:0] diff;
    logic [C:0]        adist;
    for (int c = 0; c < 3; c++) begin
      best_next[c]  = best[c];
      found_next[c] = found[c];
      eoff_next[c]  = eoff[c];
      eline_next[c] = eline[c];
      esp0_next[c]  = esp0[c];
      esp1_next[c]  = esp1[c];
      for (int j = 0; j < 3; j++) begin
        diff  = (C+1)'(ts[j]) - (C+1)'(cs[c]);
        adist = diff[C] ? (C+1)'(-diff) : (C+1)'(diff);
        if (DW'(adist) <= best_next[c]) begin
          best_next[c]  = DW'(adist);
          found_next[c] = 1'b1;
          eoff_next[c]  = diff;
          eline_next[c] = ts[j];
          esp0_next[c]  = tsp0;
          esp1_next[c]  = tsp1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      for (int c = 0; c < 3; c++) begin
        best[c]  <= DW'(thr);
        found[c] <= 1'b0;
      end
      nlo_v <= 1'b0;
      nhi_v <= 1'b0;
    end else if (upd) begin
      for (int c = 0; c < 3; c++) begin
        best[c]  <= best_next[c];
        found[c] <= found_next[c];
        eoff[c]  <= eoff_next[c];
        eline[c] <= eline_next[c];
        esp0[c]  <= esp0_next[c];
        esp1[c]  <= esp1_next[c];
      end
      // first one kept on a tie
      if (is_lo && (!nlo_v || g_lo < glo)) begin
        nlo_v <= 1'b1;
        glo   <= g_lo;
        a_s1  <= t_s1;
        a_x0  <= t_x0;
        a_x1  <= t_x1;
      end
      if (is_hi && (!nhi_v || g_hi < ghi)) begin
        nhi_v <= 1'b1;
        ghi   <= g_hi;
        b_s0  <= t_s0;
        b_x0  <= t_x0;
        b_x1  <= t_x1;
      end
    end
  end

  // fit stage: merge trackers, equal-spacing offset
  logic [DW-1:0]        m_best;
  logic                 m_found;
  logic signed [C:0]    m_off;
  logic signed [C-1:0]  m_line, m_sp0, m_sp1;
  logic signed [EW-1:0] size, wsum, want, o;
  logic [EW-1:0]        o_abs;
  logic signed [C-1:0]  lo0, hi0;

  always_comb begin
    m_best  = DW'(thr);
    m_found = 1'b0;
    m_off   = '0;
    m_line  = '0;
    m_sp0   = '0;
    m_sp1   = '0;
    for (int c = 0; c < 3; c++) begin
      if (found[c] && best[c] <= m_best) begin
        m_best  = best[c];
        m_found = 1'b1;
        m_off   = eoff[c];
        m_line  = eline[c];
        m_sp0   = esp0[c];
        m_sp1   = esp1[c];
      end
    end
  end

  assign size  = EW'(c_s1) - EW'(c_s0);
  assign wsum  = EW'(b_s0) - size + EW'(a_s1);
  assign want  = wsum >>> 1;
  assign o     = want - EW'(c_s0);
  assign o_abs = o[EW-1] ? EW'(-o) : EW'(o);
  assign lo0   = (a_x0 < c_x0) ? a_x0 : c_x0;
  assign hi0   = (a_x1 > c_x1) ? a_x1 : c_x1;

  always_ff @(posedge clk) begin
    if (fit) begin
      e_found <= m_found;
      e_off   <= m_off;
      e_line  <= m_line;
      e_sp0   <= m_sp0;
      e_sp1   <= m_sp1;
      f_ok    <= nlo_v && nhi_v && (KW'(o_abs) <= KW'(thr));
      f_off   <= o;
      f_line  <= want;
      f_sp0   <= (b_x0 < lo0) ? b_x0 : lo0;
      f_sp1   <= (b_x1 > hi0) ? b_x1 : hi0;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      if (f_ok) begin
        active <= 1'b1;
        off    <= f_off;
        line   <= sat_c(f_line);
        sp0    <= f_sp0;
        sp1    <= f_sp1;
      end else if (e_found) begin
        active <= 1'b1;
        off    <= EW'(e_off);
        line   <= e_line;
        sp0    <= e_sp0;
        sp1    <= e_sp1;
      end else begin
        active <= 1'b0;
        off    <= '0;
        line   <= '0;
        sp0    <= '0;
        sp1    <= '0;
      end
    end
  end

endmodule

// ----- design/ras_dp.sv -----
// datapath: target memory, candidate frame, both axes and result register
module ras_dp #(
  parameter int C = ras_pkg::COORD_BITS_DEF,
  parameter int MAX_TARGETS = ras_pkg::MAX_TARGETS_DEF,
  parameter int AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ras_pkg::cmd_t             cmd,
  output ras_pkg::stat_t            stat,
  input  logic [AW-1:0]             waddr,
  input  logic [AW-1:0]             raddr,
  input  logic [ras_pkg::THR_W-1:0] thr,
  input  logic signed [C-1:0]       rect_left,
  input  logic signed [C-1:0]       rect_top,
  input  logic signed [C-1:0]       rect_right,
  input  logic signed [C-1:0]       rect_bottom,
  input  logic signed [C-1:0]       move_dx,
  input  logic signed [C-1:0]       move_dy,
  ras_out_if.source                 out_ch
);
  import ras_pkg::*;

  localparam int EW = C + 4;
  localparam logic signed [EW-1:0] HI = EW'((64'sd1 <<< (C - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] LO = -HI - EW'(1);

  function automatic logic signed [C-1:0] sat_c(input logic signed [EW-1:0] v);
    if (v > HI) return HI[C-1:0];
    else if (v < LO) return LO[C-1:0];
    else return v[C-1:0];
  endfunction

  logic [4*C-1:0] mem [MAX_TARGETS];
  logic [4*C-1:0] rdata;

  always_ff @(posedge clk) begin
    if (cmd.we) mem[waddr] <= {rect_bottom, rect_right, rect_top, rect_left};
    if (cmd.re) rdata <= mem[raddr];
  end

  logic signed [C-1:0] t_l, t_t, t_r, t_b;
  assign t_l = rdata[C-1:0];
  assign t_t = rdata[2*C-1:C];
  assign t_r = rdata[3*C-1:2*C];
  assign t_b = rdata[4*C-1:3*C];

  logic signed [C-1:0] cl, ct, cr, cb, dx, dy;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cl <= sat_c(EW'(rect_left) + EW'(move_dx));
      ct <= sat_c(EW'(rect_top) + EW'(move_dy));
      cr <= sat_c(EW'(rect_right) + EW'(move_dx));
      cb <= sat_c(EW'(rect_bottom) + EW'(move_dy));
      dx <= move_dx;
      dy <= move_dy;
    end
  end

  logic                 row_act, col_act;
  logic signed [EW-1:0] row_off, col_off;
  logic signed [C-1:0]  row_line, row_sp0, row_sp1, col_line, col_sp0, col_sp1;

  ras_axis #(.C(C)) u_row (
    .clk(clk), .init(cmd.start), .upd(cmd.upd), .fit(cmd.fit), .sel(cmd.sel), .thr(thr),
    .c_s0(ct), .c_s1(cb), .c_x0(cl), .c_x1(cr),
    .t_s0(t_t), .t_s1(t_b), .t_x0(t_l), .t_x1(t_r),
    .active(row_act), .off(row_off), .line(row_line), .sp0(row_sp0), .sp1(row_sp1)
  );

  ras_axis #(.C(C)) u_col (
    .clk(clk), .init(cmd.start), .upd(cmd.upd), .fit(cmd.fit), .sel(cmd.sel), .thr(thr),
    .c_s0(cl), .c_s1(cr), .c_x0(ct), .c_x1(cb),
    .t_s0(t_l), .t_s1(t_r), .t_x0(t_t), .t_x1(t_b),
    .active(col_act), .off(col_off), .line(col_line), .sp0(col_sp0), .sp1(col_sp1)
  );

  // result register parts the scan from the output side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_ch.snap_dx           <= sat_c(EW'(dx) + col_off);
      out_ch.snap_dy           <= sat_c(EW'(dy) + row_off);
      out_ch.row_active        <= row_act;
      out_ch.row_line_y        <= row_line;
      out_ch.row_line_start    <= row_sp0;
      out_ch.row_line_end      <= row_sp1;
      out_ch.column_active     <= col_act;
      out_ch.column_line_x     <= col_line;
      out_ch.column_line_start <= col_sp0;
      out_ch.column_line_end   <= col_sp1;
    end
  end

  assign stat.out_full = out_ch.valid & ~out_ch.ready;

endmodule

// ----- design/ras_ctrl.sv -----
// controller: operation decode, table fill count and query sequencing
module ras_ctrl #(
  parameter int MAX_TARGETS = ras_pkg::MAX_TARGETS_DEF,
  parameter int AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1,
  parameter int CW = $clog2(MAX_TARGETS + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     operation,
  output logic           in_ready,
  output ras_pkg::cmd_t  cmd,
  input  ras_pkg::stat_t stat,
  output logic [AW-1:0]  waddr,
  output logic [AW-1:0]  raddr
);
  import ras_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_FIT  = 3'd3;
  localparam logic [2:0] S_SEL  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]    state, state_next;
  logic [CW-1:0] count;
  logic [AW-1:0] ai;
  logic          re_d;
  logic          xfer, last;

  assign in_ready = (state == S_IDLE);
  assign xfer     = in_valid && in_ready;
  assign last     = (CW'(ai) == count - CW'(1));
  assign waddr    = count[AW-1:0];
  assign raddr    = ai;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cmd.upd    = re_d;
    unique case (state)
      S_IDLE: begin
        if (xfer) begin
          cmd.we    = (operation == OP_APPEND) && (count < CW'(MAX_TARGETS));
          cmd.start = (operation == OP_QUERY);
          if (operation == OP_QUERY) state_next = (count == '0) ? S_WAIT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.re = 1'b1;
        if (last) state_next = S_WAIT;
      end
      S_WAIT: state_next = S_FIT;
      S_FIT: begin
        cmd.fit    = 1'b1;
        state_next = S_SEL;
      end
      S_SEL: begin
        cmd.sel    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_full) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ai    <= '0;
      re_d  <= 1'b0;
    end else begin
      state <= state_next;
      re_d  <= cmd.re;
      if (xfer && operation == OP_CLEAR) count <= '0;
      else if (cmd.we) count <= count + CW'(1);
      if (cmd.start) ai <= '0;
      else if (cmd.re) ai <= ai + AW'(1);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_TARGETS)) else $error("target count beyond table depth");
  a_read_filled: assert property (@(posedge clk) disable iff (rst)
    cmd.re |-> (CW'(ai) < count)) else $error("scan reads an unfilled entry");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !stat.out_full) else $error("result loaded over a waiting result");
  a_upd_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.re |=> cmd.upd) else $error("read data not consumed");

endmodule
